>>> design/sld_pkg.sv
`default_nettype none

package sld_pkg;

   // Frame buffer geometry.
   localparam int BUFFER_BYTES = 64;
   localparam int BUF_AW       = $clog2(BUFFER_BYTES);
   localparam int CNT_W        = BUF_AW + 1;
   // Two banks, so that one frame can be read out while the next one fills.
   localparam int BANKS        = 2;
   localparam int MEM_AW       = BUF_AW + 1;

   localparam int HEADER_BYTES = 4;
   localparam int BYTE_W       = 8;
   localparam int POS_W        = 6;
   localparam int OVH_W        = 4;
   localparam int TOTAL_W      = 10;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W    = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SYNC     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_SYNC    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_OVERHEAD = 2'd2;

   localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET     = 8'hAA;
   localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET    = 8'h55;
   localparam logic [OVH_W-1:0]  FRAME_OVERHEAD_RESET = 4'd5;

   // Write into the frame buffer, from the front end to the read-out side.
   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [BYTE_W-1:0] data;
   } buf_write_type;

   // One completed frame waiting for read-out.
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
   } frame_desc_type;

endpackage

`default_nettype wire

>>> design/sld_front.sv
`default_nettype none

module sld_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,
   input  wire logic                           csr_we,
   input  wire logic [sld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sld_pkg::BYTE_W-1:0]     csr_wdata,
   input  wire logic                           space_ok,
   output sld_pkg::buf_write_type              buf_wr,
   output logic                                desc_push,
   output sld_pkg::frame_desc_type             desc
);
   import sld_pkg::*;

   logic [BYTE_W-1:0]  first_sync_ff, first_sync_in;
   logic [BYTE_W-1:0]  second_sync_ff, second_sync_in;
   logic [OVH_W-1:0]   overhead_ff, overhead_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BYTE_W-1:0]  len_ff, len_in;
   logic               bank_ff, bank_in;

   logic [CNT_W-1:0]   cnt_plus;
   logic [BYTE_W-1:0]  len_sel;
   logic [TOTAL_W-1:0] total;
   logic [BYTE_W-1:0]  rx_byte;
   logic               take;

   assign req_tready = space_ok;
   assign rx_byte    = req_tdata[BYTE_W-1:0];
   assign take       = req_tvalid && req_tready;

   always_comb begin
      first_sync_in  = first_sync_ff;
      second_sync_in = second_sync_ff;
      overhead_in    = overhead_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_SYNC:     first_sync_in  = csr_wdata;
            CSR_SECOND_SYNC:    second_sync_in = csr_wdata;
            CSR_FRAME_OVERHEAD: overhead_in    = csr_wdata[OVH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt_plus = cnt_ff + CNT_W'(1);
      // The length byte is the fourth one, so it is taken straight from the
      // input on the beat that brings it.
      len_sel  = (cnt_ff == CNT_W'(HEADER_BYTES - 1)) ? rx_byte : len_ff;
      total    = TOTAL_W'(len_sel) + TOTAL_W'(overhead_ff);

      cnt_in      = cnt_ff;
      len_in      = len_ff;
      bank_in     = bank_ff;
      buf_wr.en   = 1'b0;
      buf_wr.addr = {bank_ff, cnt_ff[BUF_AW-1:0]};
      buf_wr.data = rx_byte;
      desc_push   = 1'b0;
      desc.bank   = bank_ff;
      desc.count  = cnt_plus;

      if (take) begin
         if (cnt_ff == '0) begin
            if (rx_byte == first_sync_ff) begin
               buf_wr.en = 1'b1;
               cnt_in    = CNT_W'(1);
            end
         end else if (cnt_ff == CNT_W'(1) && rx_byte != second_sync_ff) begin
            // A repeated first sync byte keeps the hunt at position one.
            cnt_in = (rx_byte == first_sync_ff) ? CNT_W'(1) : '0;
         end else begin
            buf_wr.en = 1'b1;
            if (cnt_ff == CNT_W'(HEADER_BYTES - 1)) begin
               len_in = rx_byte;
            end
            if (cnt_plus >= CNT_W'(HEADER_BYTES) && TOTAL_W'(cnt_plus) >= total) begin
               desc_push = 1'b1;
               cnt_in    = '0;
               bank_in   = ~bank_ff;
            end else if (cnt_plus == CNT_W'(BUFFER_BYTES)) begin
               // Buffer full before the frame completed: drop it.
               cnt_in = '0;
            end else begin
               cnt_in = cnt_plus;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= FIRST_SYNC_RESET;
         second_sync_ff <= SECOND_SYNC_RESET;
         overhead_ff    <= FRAME_OVERHEAD_RESET;
         cnt_ff         <= '0;
         bank_ff        <= 1'b0;
      end else begin
         first_sync_ff  <= first_sync_in;
         second_sync_ff <= second_sync_in;
         overhead_ff    <= overhead_in;
         cnt_ff         <= cnt_in;
         bank_ff        <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

endmodule

`default_nettype wire

>>> design/sld_queue.sv
`default_nettype none

module sld_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire sld_pkg::frame_desc_type     push_desc,
   input  wire logic                        pop,
   output logic                             not_empty,
   output sld_pkg::frame_desc_type          head,
   output logic [sld_pkg::QCNT_W-1:0]       count
);
   import sld_pkg::*;

   frame_desc_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   // Pushes only come in while there is room; the caller limits frames in flight.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

>>> design/sld_back.sv
`default_nettype none

module sld_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sld_pkg::buf_write_type     buf_wr,
   input  wire logic                       desc_valid,
   input  wire sld_pkg::frame_desc_type    desc,
   output logic                            desc_pop,
   output logic                            busy,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [15:0]                     rsp_tdata,
   output logic                            rsp_tlast
);
   import sld_pkg::*;

   logic [BYTE_W-1:0] mem [BANKS * BUFFER_BYTES];
   logic [BYTE_W-1:0] mem_q_ff;

   logic              busy_ff, busy_in;
   logic              bank_ff, bank_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BUF_AW-1:0] k_ff, k_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [POS_W-1:0]  s1_pos_ff, s1_pos_in;
   logic              s1_last_ff, s1_last_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic              out_last_ff, out_last_in;

   logic              advance;
   logic              issue;
   logic              is_last;

   assign advance  = !out_valid_ff || rsp_tready;
   assign issue    = busy_ff && (!s1_valid_ff || advance);
   assign is_last  = (CNT_W'(k_ff) + CNT_W'(1) == count_ff);
   assign desc_pop = !busy_ff && desc_valid;
   assign busy     = busy_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_pos_ff, out_data_ff};
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      busy_in      = busy_ff;
      bank_in      = bank_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      s1_valid_in  = s1_valid_ff;
      s1_pos_in    = s1_pos_ff;
      s1_last_in   = s1_last_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;

      if (desc_pop) begin
         busy_in  = 1'b1;
         bank_in  = desc.bank;
         count_in = desc.count;
         k_in     = '0;
      end

      if (advance) begin
         out_valid_in = s1_valid_ff;
         out_data_in  = mem_q_ff;
         out_pos_in   = s1_pos_ff;
         out_last_in  = s1_last_ff;
         s1_valid_in  = 1'b0;
      end

      if (issue) begin
         s1_valid_in = 1'b1;
         s1_pos_in   = POS_W'(k_ff);
         s1_last_in  = is_last;
         k_in        = k_ff + BUF_AW'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff     <= bank_in;
      count_ff    <= count_in;
      k_ff        <= k_in;
      s1_pos_ff   <= s1_pos_in;
      s1_last_ff  <= s1_last_in;
      out_data_ff <= out_data_in;
      out_pos_ff  <= out_pos_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         mem[buf_wr.addr] <= buf_wr.data;
      end
      if (issue) begin
         mem_q_ff <= mem[{bank_ff, k_ff}];
      end
   end

endmodule

`default_nettype wire

>>> design/sync_length_byte_deframer.sv
// Two-byte sync, length-prefixed byte deframer.
//
// The req_ channel takes one received serial byte per beat. The front end
// hunts for the first and second sync bytes, stores the frame in one of two
// 64-byte banks and reads the payload length from the fourth byte. A frame is
// complete when its byte count reaches length plus frame_overhead (at least
// the four header bytes); a frame that fills the buffer first is dropped.
// Each completed frame goes out on the rsp_ channel as a burst of beats, one
// per frame byte, with its position in tdata and tlast on the final byte.
//
// Throughput: one input byte per cycle while fewer than two completed frames
// wait for or are in read-out; the two buffer banks set that limit. Read-out
// runs one byte per cycle while rsp_tready allows, through a registered memory
// read and an output register; each frame is taken from the frame queue.
// The csr_ port writes first_sync, second_sync and frame_overhead; the user
// must write them only while idle, which the block itself does not enforce.
// Reset clears the hunt, the frame queue and the output, and restores the
// register defaults. A stalled receiver holds the output beat and backs up
// into req_tready once both banks are occupied.

`default_nettype none

module sync_length_byte_deframer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,   // [7:0] rx_byte
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [7:0] frame_byte, [13:8] byte_position
   output logic                                rsp_tlast,   // last_byte
   input  wire logic                           csr_we,
   input  wire logic [sld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sld_pkg::BYTE_W-1:0]     csr_wdata
);
   import sld_pkg::*;

   buf_write_type      buf_wr;
   logic               desc_push;
   frame_desc_type     push_desc;
   logic               desc_pop;
   logic               desc_valid;
   frame_desc_type     head_desc;
   logic [QCNT_W-1:0]  q_count;
   logic               back_busy;
   logic               space_ok;

   // Each bank holds one frame; the front may fill only while a bank is free.
   assign space_ok = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(back_busy))
                     < (QCNT_W + 1)'(BANKS);

   sld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .space_ok   (space_ok),
      .buf_wr     (buf_wr),
      .desc_push  (desc_push),
      .desc       (push_desc)
   );

   sld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (push_desc),
      .pop       (desc_pop),
      .not_empty (desc_valid),
      .head      (head_desc),
      .count     (q_count)
   );

   sld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .buf_wr     (buf_wr),
      .desc_valid (desc_valid),
      .desc       (head_desc),
      .desc_pop   (desc_pop),
      .busy       (back_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
